@@ rtl/tlm_pkg.sv @@
package tlm_pkg;

  localparam int unsigned ActBits   = 16;
  localparam int unsigned AccBits   = 32;
  localparam int unsigned BiasBits  = 32;
  localparam int unsigned CodeBits  = 5;
  localparam int unsigned ColBits   = 10;
  localparam int unsigned Columns   = 1024;
  // three activations summed: two extra bits cover sum and negation
  localparam int unsigned TermBits  = ActBits + 2;
  localparam int unsigned CodeNegPos = 4;
  localparam int unsigned PatCount   = 16;

  // ternary weight digit
  typedef enum logic [1:0] {
    WtNeg  = 2'd0,
    WtZero = 2'd1,
    WtPos  = 2'd2
  } tlm_wt_e;

  // pattern index -> {digit2, digit1, digit0}; unused patterns are all zero weights
  localparam logic [5:0] PatTable [PatCount] = '{
    6'h00, 6'h01, 6'h02, 6'h04, 6'h05, 6'h06, 6'h08, 6'h09,
    6'h0A, 6'h10, 6'h11, 6'h12, 6'h14, 6'h15, 6'h15, 6'h15
  };

  typedef struct packed {
    logic signed [ActBits-1:0]  act_0;
    logic signed [ActBits-1:0]  act_1;
    logic signed [ActBits-1:0]  act_2;
    logic        [CodeBits-1:0] code;
    logic        [ColBits-1:0]  column;
    logic signed [BiasBits-1:0] bias;
    logic                       first_group;
    logic                       last_group;
  } tlm_in_t;

  typedef struct packed {
    logic        [ColBits-1:0] out_column;
    logic signed [AccBits-1:0] out_value;
  } tlm_out_t;

  // column accumulator write request
  typedef struct packed {
    logic                      en;
    logic        [ColBits-1:0] column;
    logic signed [AccBits-1:0] value;
  } tlm_wr_t;

  // accumulate stage contents
  typedef struct packed {
    logic        [ColBits-1:0]  column;
    logic signed [TermBits-1:0] term;
    logic signed [AccBits-1:0]  base;
    logic                       last_group;
  } tlm_acc_t;

endpackage

@@ rtl/tlm_in_if.sv @@
interface tlm_in_if;
  import tlm_pkg::*;

  logic    valid;
  logic    ready;
  tlm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tlm_out_if.sv @@
interface tlm_out_if;
  import tlm_pkg::*;

  logic     valid;
  logic     ready;
  tlm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tlm_term.sv @@
module tlm_term (
  input  logic signed [tlm_pkg::ActBits-1:0]  act_0_i,
  input  logic signed [tlm_pkg::ActBits-1:0]  act_1_i,
  input  logic signed [tlm_pkg::ActBits-1:0]  act_2_i,
  input  logic        [tlm_pkg::CodeBits-1:0] code_i,
  output logic signed [tlm_pkg::TermBits-1:0] term_o
);
  import tlm_pkg::*;

  logic        [5:0]          pat;
  logic signed [TermBits-1:0] part [3];
  logic signed [TermBits-1:0] ext  [3];
  logic signed [TermBits-1:0] sum;

  assign pat    = PatTable[code_i[CodeNegPos-1:0]];
  assign ext[0] = TermBits'(act_0_i);
  assign ext[1] = TermBits'(act_1_i);
  assign ext[2] = TermBits'(act_2_i);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (tlm_wt_e'(pat[2*i +: 2]))
        WtNeg:   part[i] = -ext[i];
        WtPos:   part[i] = ext[i];
        default: part[i] = '0;
      endcase
    end
  end

  assign sum    = part[0] + part[1] + part[2];
  assign term_o = code_i[CodeNegPos] ? -sum : sum;

endmodule

@@ rtl/tlm_colmem.sv @@
module tlm_colmem (
  input  logic                               clk_i,
  input  logic                               rd_en_i,
  input  logic        [tlm_pkg::ColBits-1:0] rd_addr_i,
  output logic signed [tlm_pkg::AccBits-1:0] rd_data_o,
  input  tlm_pkg::tlm_wr_t                   wr_i
);
  import tlm_pkg::*;

  logic signed [AccBits-1:0] mem_q [Columns];
  logic signed [AccBits-1:0] rd_data_q;

  // read returns the value from before a same-edge write
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.column] <= wr_i.value;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/ternary_lut_matvec_accumulate.sv @@
// Ternary-weight lookup matrix-vector accumulator.
// in_i carries one group per request: three signed activations, a 5-bit
// weight code, the output column, a bias and first/last-group flags.
// out_o carries one finished column total per request with last_group set.
// Both channels use valid/ready; a request moves when both are high.
// Pipeline: input/memory-read stage, term and forwarding stage, then the
// saturating accumulate that writes the column memory and the output
// register. Throughput is one group per cycle while in_i.ready is high,
// including back-to-back groups of the same column; the registered read
// of the column memory misses the two writes still in flight, and
// forwarding from those two covers it.
// Reset clears all valid bits; the column memory is not cleared, so every
// row must start with a first group.
// When the receiver stalls, groups keep flowing until a group that emits a
// result reaches the accumulate stage while the output is still held; then
// in_i.ready drops until out_o is taken.
module ternary_lut_matvec_accumulate (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlm_in_if.sink    in_i,
  tlm_out_if.source out_o
);
  import tlm_pkg::*;

  logic                       adv;
  logic                       accept;
  logic                       load_out;

  logic                       s1_valid_q;
  tlm_in_t                    s1_q;
  logic signed [AccBits-1:0]  rd_data;
  logic signed [TermBits-1:0] term;
  logic signed [AccBits-1:0]  fwd_base;

  logic                       s2_valid_q;
  tlm_acc_t                   s2_q;
  tlm_acc_t                   s2_d;
  logic signed [AccBits:0]    sum_wide;
  logic signed [AccBits-1:0]  acc_new;

  logic                       wr_valid_q;
  tlm_wr_t                    wr_q;
  tlm_wr_t                    wr;

  logic                       out_valid_q;
  tlm_out_t                   out_q;

  // hold the core only when a result is due and the output is still occupied
  assign adv      = !(s2_valid_q && s2_q.last_group && out_valid_q && !out_o.ready);
  assign accept   = in_i.valid && adv;
  assign load_out = adv && s2_valid_q && s2_q.last_group;
  assign in_i.ready = adv;

  tlm_colmem u_colmem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (in_i.data.column),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  tlm_term u_term (
    .act_0_i (s1_q.act_0),
    .act_1_i (s1_q.act_1),
    .act_2_i (s1_q.act_2),
    .code_i  (s1_q.code),
    .term_o  (term)
  );

  // newest value of the column wins: accumulate stage, then last write, then memory
  always_comb begin
    if (s2_valid_q && s2_q.column == s1_q.column) begin
      fwd_base = acc_new;
    end else if (wr_valid_q && wr_q.column == s1_q.column) begin
      fwd_base = wr_q.value;
    end else begin
      fwd_base = rd_data;
    end
    s2_d.column     = s1_q.column;
    s2_d.term       = term;
    s2_d.base       = s1_q.first_group ? s1_q.bias : fwd_base;
    s2_d.last_group = s1_q.last_group;
  end

  // saturating accumulate
  always_comb begin
    sum_wide = (AccBits+1)'(s2_q.base) + (AccBits+1)'(s2_q.term);
    if (sum_wide[AccBits] != sum_wide[AccBits-1]) begin
      acc_new = sum_wide[AccBits] ? {1'b1, {(AccBits-1){1'b0}}}
                                  : {1'b0, {(AccBits-1){1'b1}}};
    end else begin
      acc_new = sum_wide[AccBits-1:0];
    end
  end

  assign wr.en     = adv && s2_valid_q;
  assign wr.column = s2_q.column;
  assign wr.value  = acc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_q <= in_i.valid;
        s2_valid_q <= s1_valid_q;
        wr_valid_q <= s2_valid_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_i.data;
    end
    if (adv) begin
      s2_q <= s2_d;
      wr_q <= wr;
    end
    if (load_out) begin
      out_q.out_column <= s2_q.column;
      out_q.out_value  <= acc_new;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s2_valid_q && s2_q.last_group && out_valid_q))
    else $error("input held without a pending result");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_valid_q && s2_q.last_group))
    else $error("result raised without a last group");

  a_wr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_valid_q) |=> (wr_valid_q && wr_q.column == $past(s2_q.column)))
    else $error("forwarding register lost a write");

endmodule
